// File: rtl/frame_crc16_check_stamp_unit_macros.svh
// Assertion macros shared by the frame CRC check/stamp RTL.
// Each macro expects clk and rst_n to be visible in the using module.
`ifndef FRAME_CRC16_CHECK_STAMP_UNIT_MACROS_SVH
`define FRAME_CRC16_CHECK_STAMP_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FCS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define FCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/fcs_pkg.sv
// Package for the frame CRC-16 check/stamp unit: result types, constants
// and the byte-wide CRC-16 update function. No dependencies.
package fcs_pkg;

  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam logic [15:0] CRC_INIT  = 16'h0000;
  localparam logic [2:0]  COUNT_MAX = 3'd7;
  // Frame of at least five bytes means at least four bytes before the final one.
  localparam logic [2:0]  MIN_COUNT = 3'd4;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);
  // A final byte can produce three results.
  localparam int MAX_PUSH = 3;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_frame;
    logic       frame_ok;
  } res_t;

  typedef struct packed {
    logic [1:0]      n;
    res_t [2:0]      res;
  } push_t;

  // CRC-16, MSB first, one byte per call.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: rtl/frame_crc16_check_stamp_unit.sv
// Top level of the frame CRC-16 check/stamp unit.
// Depends on fcs_pkg, fcs_core and fcs_outq.
//
//  Port group  Direction  Handshake          Payload
//  in_*        input      in_valid/in_ready  in_data_byte, in_is_final
//  out_*       output     out_valid/out_ready out_byte, out_end_of_frame, out_frame_ok
//  cfg_*       input      cfg_we             cfg_mode
//
// An accepted byte updates the frame state in the same cycle and its
// results (none or one for a body byte, one to three for the final byte)
// land in a four-entry result queue; the first can leave in the next cycle.
// The input takes one byte per cycle while the queue holds at most one
// item, so a stream of body bytes runs at one item per cycle while out_ready
// stays high; after a final byte the output port sets the pace at one result
// per cycle. Reset is synchronous and active low; it clears the mode to check,
// the CRC, the byte counter and the queue. A stall on out_ready lets the queue
// grow past one item, which drops in_ready; nothing is lost.

module frame_crc16_check_stamp_unit
  import fcs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_mode,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_is_final,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_end_of_frame,
  output logic       out_frame_ok
);

  push_t push;
  res_t  head;
  logic  room;
  logic  in_acc;

  // The ready comes from registered queue state only.
  assign in_ready = room;
  assign in_acc   = in_valid && room;

  fcs_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_mode     (cfg_mode),
    .in_acc       (in_acc),
    .in_data_byte (in_data_byte),
    .in_is_final  (in_is_final),
    .push         (push)
  );

  fcs_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (head)
  );

  assign out_byte         = head.out_byte;
  assign out_end_of_frame = head.end_of_frame;
  assign out_frame_ok     = head.frame_ok;

endmodule

// File: rtl/fcs_core.sv
// Frame state for the CRC-16 check/stamp unit: mode register, delay line,
// byte counter and CRC accumulator. Uses fcs_pkg and the assertion macros.
`include "frame_crc16_check_stamp_unit_macros.svh"

module fcs_core
  import fcs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_mode,
  input  logic       in_acc,
  input  logic [7:0] in_data_byte,
  input  logic       in_is_final,
  output push_t      push
);

  logic        mode_r;
  logic [15:0] crc_r, crc_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [7:0]  held_r [2];
  logic [7:0]  held_nxt [2];
  logic        long_enough;
  logic [7:0]  h0, h1;
  logic        ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_we) begin
      mode_r <= cfg_mode;
    end
  end

  always_comb begin
    crc_nxt     = crc_r;
    cnt_nxt     = cnt_r;
    held_nxt    = held_r;
    push        = '0;
    long_enough = (cnt_r >= MIN_COUNT);
    h0          = held_r[0];
    h1          = held_r[1];
    ok          = 1'b0;

    if (long_enough) begin
      if (mode_r) begin
        h0 = crc_r[15:8];
        h1 = crc_r[7:0];
        ok = 1'b1;
      end else begin
        ok = ({held_r[0], held_r[1]} == crc_r);
      end
    end

    if (in_acc) begin
      if (!in_is_final) begin
        if (cnt_r >= 3'd2) begin
          push.n      = 2'd1;
          push.res[0] = '{out_byte: held_r[0], end_of_frame: 1'b0, frame_ok: 1'b0};
          crc_nxt     = crc16_byte(crc_r, held_r[0]);
          held_nxt[0] = held_r[1];
          held_nxt[1] = in_data_byte;
        end else begin
          held_nxt[cnt_r[0]] = in_data_byte;
        end
        if (cnt_r != COUNT_MAX) begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end else begin
        if (cnt_r >= 3'd2) begin
          push.n      = 2'd3;
          push.res[0] = '{out_byte: h0, end_of_frame: 1'b0, frame_ok: 1'b0};
          push.res[1] = '{out_byte: h1, end_of_frame: 1'b0, frame_ok: 1'b0};
          push.res[2] = '{out_byte: in_data_byte, end_of_frame: 1'b1, frame_ok: ok};
        end else if (cnt_r == 3'd1) begin
          push.n      = 2'd2;
          push.res[0] = '{out_byte: h0, end_of_frame: 1'b0, frame_ok: 1'b0};
          push.res[1] = '{out_byte: in_data_byte, end_of_frame: 1'b1, frame_ok: ok};
        end else begin
          push.n      = 2'd1;
          push.res[0] = '{out_byte: in_data_byte, end_of_frame: 1'b1, frame_ok: ok};
        end
        crc_nxt = CRC_INIT;
        cnt_nxt = 3'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= CRC_INIT;
      cnt_r <= 3'd0;
    end else begin
      crc_r <= crc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // The delay line holds payload only.
  always_ff @(posedge clk) begin
    held_r <= held_nxt;
  end

  `FCS_ASSERT_NEXT(a_frame_clears, in_acc && in_is_final, (cnt_r == 3'd0) && (crc_r == CRC_INIT), "frame state not cleared after final byte")
  `FCS_ASSERT_NOW(a_one_evict, in_acc && !in_is_final && (cnt_r >= 3'd2), push.n == 2'd1, "non-final byte with full delay line must emit one item")
  `FCS_ASSERT_NOW(a_final_emits, in_acc && in_is_final, push.res[push.n - 2'd1].end_of_frame, "last item of a final byte must carry end of frame")

endmodule

// File: rtl/fcs_outq.sv
// Result queue for the frame CRC-16 check/stamp unit: takes up to three
// items per cycle, returns one. Uses fcs_pkg and the assertion macros.
`include "frame_crc16_check_stamp_unit_macros.svh"

module fcs_outq
  import fcs_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  output logic  room,
  output logic  out_valid,
  input  logic  out_ready,
  output res_t  out_res
);

  res_t             q_r [QDEPTH];
  logic [QAW-1:0]   wr_r, rd_r;
  logic [QCW-1:0]   cnt_r, cnt_nxt;
  logic             pop;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && out_ready;
  assign out_res   = q_r[rd_r];
  // Room for the worst case of a final byte.
  assign room      = (cnt_r <= QCW'(QDEPTH - MAX_PUSH));

  assign cnt_nxt = cnt_r + QCW'(push.n) - QCW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + QAW'(push.n);
      rd_r  <= rd_r + QAW'(pop);
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_PUSH; i++) begin
      if (2'(i) < push.n) begin
        q_r[wr_r + QAW'(i)] <= push.res[i];
      end
    end
  end

  `FCS_ASSERT_NOW(a_no_overflow, push.n != 2'd0, room, "items pushed without room in the queue")
  `FCS_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= QCW'(QDEPTH), "queue count beyond depth")
  `FCS_ASSERT_NEXT(a_cnt_hold, (push.n == 2'd0) && !pop, $stable(cnt_r), "queue count moved without push or pop")

endmodule

// File: dv/tb_frame_crc16_check_stamp_unit.sv
`timescale 1ns / 100ps
// Testbench for frame_crc16_check_stamp_unit: directed and random frames in check
// and stamp mode, checked against a CRC-16 frame predictor. Depends on fcs_pkg.
module tb_frame_crc16_check_stamp_unit;
  import fcs_pkg::*;

  // Values of the one configuration register.
  localparam logic MODE_CHECK = 1'b0;
  localparam logic MODE_STAMP = 1'b1;

  // Cycles allowed after the last expected result before the block is
  // considered idle. A body byte that yields no result may still be in flight.
  localparam int SETTLE_CYCLES = 4;
  // Length of the long receiver hold-off used to fill the result queue.
  localparam int HOLD_CYCLES   = 60;
  localparam int MAX_REPORTS   = 10;

  typedef logic [7:0] frame_bytes_t[$];

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic       cfg_mode = MODE_CHECK;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_is_final = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_end_of_frame;
  logic       out_frame_ok;

  // Traffic shaping, in percent per cycle.
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  // Set by a test to ask the receiver for one long hold-off; the receiver clears it.
  bit hold_request = 1'b0;

  // Predictor state: a private copy of the frame logic and the mode register.
  logic        stamp_mode;
  logic [15:0] running_crc;
  logic [7:0]  held_byte [2];
  logic [2:0]  body_count;
  res_t        expected_results[$];

  int mismatches = 0;
  int items_sent = 0;

  frame_crc16_check_stamp_unit uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_mode         (cfg_mode),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_is_final      (in_is_final),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_end_of_frame (out_end_of_frame),
    .out_frame_ok     (out_frame_ok)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Watchdog. It leaves a wide margin over the slowest legal run.
  initial begin
    #3_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // CRC-16 update, one data bit at a time: the feedback bit is the top CRC
  // bit xored with the incoming data bit, MSB first.
  function automatic logic [15:0] crc_shift_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] acc;
    logic        fb;
    acc = crc;
    for (int i = 7; i >= 0; i--) begin
      fb  = acc[15] ^ b[i];
      acc = {acc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return acc;
  endfunction

  function automatic void clear_frame_state();
    running_crc  = CRC_INIT;
    held_byte[0] = 8'h00;
    held_byte[1] = 8'h00;
    body_count   = 3'd0;
  endfunction

  // Works out the results that one accepted byte causes and queues them.
  // Body bytes go through a two-deep delay line; the byte leaving it feeds
  // the CRC. The final byte flushes the delay line, possibly with the CRC
  // stamped in its place.
  task automatic predict_frame_byte(input logic [7:0] b, input logic fin);
    logic [7:0] hi_byte;
    logic [7:0] lo_byte;
    logic       ok;
    if (!fin) begin
      if (body_count >= 3'd2) begin
        running_crc = crc_shift_byte(running_crc, held_byte[0]);
        expected_results.push_back(res_t'{held_byte[0], 1'b0, 1'b0});
        held_byte[0] = held_byte[1];
        held_byte[1] = b;
      end else begin
        held_byte[body_count[0]] = b;
      end
      if (body_count != COUNT_MAX) begin
        body_count = body_count + 3'd1;
      end
    end else begin
      hi_byte = held_byte[0];
      lo_byte = held_byte[1];
      ok      = 1'b0;
      // A frame counts as long enough with at least four bytes ahead of the
      // final one; only then is the CRC checked or stamped.
      if (body_count >= MIN_COUNT) begin
        if (stamp_mode == MODE_STAMP) begin
          hi_byte = running_crc[15:8];
          lo_byte = running_crc[7:0];
          ok      = 1'b1;
        end else begin
          ok = ({hi_byte, lo_byte} == running_crc);
        end
      end
      if (body_count >= 3'd2) begin
        expected_results.push_back(res_t'{hi_byte, 1'b0, 1'b0});
        expected_results.push_back(res_t'{lo_byte, 1'b0, 1'b0});
      end else if (body_count == 3'd1) begin
        expected_results.push_back(res_t'{hi_byte, 1'b0, 1'b0});
      end
      expected_results.push_back(res_t'{b, 1'b1, ok});
      running_crc = CRC_INIT;
      body_count  = 3'd0;
    end
  endtask

  // ---------------------------------------------------------------------
  // Result side: random or held ready, and the scoreboard compare.
  // ---------------------------------------------------------------------

  // The hold-off is counted here so that the sender keeps running on its own
  // and runs into a full result queue.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic void report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
  endfunction

  // Every accepted result is compared with the oldest expectation. Outputs
  // are sampled at the edge, before the block updates them.
  always @(posedge clk) begin : result_scoreboard
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result byte=%02h eof=%0b ok=%0b",
                                  out_byte, out_end_of_frame, out_frame_ok));
      end else begin
        want = expected_results.pop_front();
        if (out_byte !== want.out_byte) begin
          report_mismatch($sformatf("out_byte expected %02h actual %02h",
                                    want.out_byte, out_byte));
        end
        if (out_end_of_frame !== want.end_of_frame) begin
          report_mismatch($sformatf("end_of_frame expected %0b actual %0b",
                                    want.end_of_frame, out_end_of_frame));
        end
        if (out_frame_ok !== want.frame_ok) begin
          report_mismatch($sformatf("frame_ok expected %0b actual %0b (byte %02h)",
                                    want.frame_ok, out_frame_ok, want.out_byte));
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------

  // Geometric idle gap: each cycle idles with the given chance.
  function automatic int idle_gap(input int pct);
    int n;
    n = 0;
    while (n < 40 && $urandom_range(99) < pct) begin
      n++;
    end
    return n;
  endfunction

  // Offers one item and holds it until accepted. Valid is only dropped when
  // a gap follows, so back-to-back items keep it high without a glitch.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_is_final  <= fin;
    do begin
      @(posedge clk);
    end while (!in_ready);
    predict_frame_byte(b, fin);
    items_sent++;
    gap = idle_gap(sender_idle_pct);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Sends a frame; with fix_crc set, a frame of five or more bytes gets the
  // correct CRC in the two bytes ahead of the final one.
  task automatic send_frame(input frame_bytes_t bytes, input bit fix_crc);
    logic [15:0] crc;
    int          len;
    len = bytes.size();
    if (fix_crc && len >= 5) begin
      crc = CRC_INIT;
      for (int i = 0; i < len - 3; i++) begin
        crc = crc_shift_byte(crc, bytes[i]);
      end
      bytes[len-3] = crc[15:8];
      bytes[len-2] = crc[7:0];
    end
    for (int i = 0; i < len; i++) begin
      send_byte(bytes[i], i == len - 1);
    end
  endtask

  // Stops offering items and waits until every expected result has come,
  // then lets the block settle for a body byte that causes no result.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_mode <= m;
    @(posedge clk);
    cfg_we     <= 1'b0;
    stamp_mode = m;
  endtask

  function automatic frame_bytes_t random_frame(input int len);
    frame_bytes_t f;
    for (int i = 0; i < len; i++) begin
      f.push_back(8'($urandom_range(255)));
    end
    return f;
  endfunction

  // Mostly 5 to 9 bytes, with short frames and saturating long ones mixed in.
  function automatic int random_frame_len();
    int pick;
    pick = $urandom_range(99);
    if (pick < 15) begin
      return $urandom_range(1, 4);
    end else if (pick < 85) begin
      return $urandom_range(5, 9);
    end
    return $urandom_range(10, 20);
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Frames of one to four bytes pass unchanged and always fail the check,
  // whichever mode is set. The delay line is not full in the one- and two-byte frames.
  task automatic test_short_frames();
    send_frame('{8'hFF}, 1'b0);
    send_frame('{8'h00, 8'hFF}, 1'b0);
    write_mode(MODE_STAMP);
    send_frame('{8'hA5, 8'h5A, 8'h80, 8'h01}, 1'b0);
  endtask

  // Check mode with a correct CRC over all-ones data, then a longer
  // frame of zero data whose trailer does not match.
  task automatic test_check_mode();
    write_mode(MODE_CHECK);
    send_frame('{8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF}, 1'b1);
    send_frame('{8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00}, 1'b0);
  endtask

  // Stamp mode on a frame long enough to saturate the length counter.
  task automatic test_stamp_saturated();
    write_mode(MODE_STAMP);
    send_frame(random_frame(9), 1'b0);
  endtask

  // The mode is taken when the final byte arrives: body bytes go in under
  // check mode, the final one under stamp mode.
  task automatic test_mode_change_mid_frame();
    write_mode(MODE_CHECK);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b0);
    send_byte(8'h78, 1'b0);
    write_mode(MODE_STAMP);
    send_byte(8'h9A, 1'b1);
  endtask

  // The receiver holds off for a long stretch while the sender streams
  // without gaps, so the result queue fills and the input stalls. Then the
  // sender waits for every result before going on.
  task automatic test_backpressure();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    write_mode(MODE_CHECK);
    hold_request = 1'b1;
    for (int k = 0; k < 5; k++) begin
      send_frame(random_frame($urandom_range(5, 10)), k[0]);
    end
    wait_idle();
  endtask

  // Random frames, mostly well formed. In check mode most frames carry a
  // correct CRC; the rest are random trailers. The mode flips now and then
  // while the block is idle.
  task automatic test_random_frames(input int n_items, input int idle_pct, input int stall_pct);
    int target;
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    target = items_sent + n_items;
    while (items_sent < target) begin
      if ($urandom_range(99) < 12) begin
        write_mode(~stamp_mode);
      end
      send_frame(random_frame(random_frame_len()), $urandom_range(99) < 65);
    end
    wait_idle();
  endtask

  initial begin
    stamp_mode = MODE_CHECK;
    clear_frame_state();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_short_frames();
    test_check_mode();
    test_stamp_saturated();
    test_mode_change_mid_frame();
    test_backpressure();
    test_random_frames(62, 0, 0);
    test_random_frames(62, 78, 0);
    test_random_frames(62, 0, 78);
    test_random_frames(62, 30, 30);

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
